### hdl/triangle_box_edge_cross_test_core_assert.svh
// assertion macros for the triangle box edge cross test core
`ifndef TRIANGLE_BOX_EDGE_CROSS_TEST_CORE_ASSERT_SVH
`define TRIANGLE_BOX_EDGE_CROSS_TEST_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TBEC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TBEC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tbec_pkg.sv
// shared types, constants and sign helpers for the triangle box edge cross test
package tbec_pkg;

	localparam int CoordBits  = 16;
	localparam int DiffBits   = CoordBits + 1;
	localparam int ProdBits   = 2 * DiffBits;
	localparam int KeyBits    = 2 * CoordBits;
	localparam int NumVerts   = 3;
	localparam int NumCorners = 4;
	localparam int NumPairs   = NumVerts * NumCorners;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffBits-1:0]  diff_t;
	typedef logic signed [ProdBits-1:0]  prod_t;
	typedef logic [KeyBits-1:0]          key_t;
	typedef logic signed [1:0]           sgn_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	localparam sgn_t SgnPos  = 2'sb01;
	localparam sgn_t SgnZero = 2'sb00;
	localparam sgn_t SgnNeg  = 2'sb11;

	function automatic diff_t d_sub(input coord_t a, input coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	function automatic sgn_t sgn_of(input diff_t d);
		if (d == '0)
			return SgnZero;
		else if (d[DiffBits-1])
			return SgnNeg;
		else
			return SgnPos;
	endfunction

	function automatic sgn_t sgn_cmp(input prod_t lhs, input prod_t rhs);
		if (lhs > rhs)
			return SgnPos;
		else if (lhs < rhs)
			return SgnNeg;
		else
			return SgnZero;
	endfunction

	function automatic sgn_t sgn_neg(input sgn_t a);
		if (a == SgnPos)
			return SgnNeg;
		else if (a == SgnNeg)
			return SgnPos;
		else
			return SgnZero;
	endfunction

	function automatic sgn_t sgn_mul(input sgn_t a, input sgn_t b);
		if (a == SgnZero || b == SgnZero)
			return SgnZero;
		else if (a == b)
			return SgnPos;
		else
			return SgnNeg;
	endfunction

	// unsigned key whose order is the signed (x, y) lexicographic order
	function automatic key_t lex_key(input pt_t p);
		return {~p.x[CoordBits-1], p.x[CoordBits-2:0], ~p.y[CoordBits-1], p.y[CoordBits-2:0]};
	endfunction

	function automatic logic seg_touch(input sgn_t o_abc, input sgn_t o_abd,
		input sgn_t o_cda, input sgn_t o_cdb, input logic ovl);
		logic zero1;
		logic zero2;
		logic le1;
		logic le2;
		zero1 = (o_abc == SgnZero) || (o_abd == SgnZero);
		zero2 = (o_cda == SgnZero) || (o_cdb == SgnZero);
		le1   = zero1 || (o_abc != o_abd);
		le2   = zero2 || (o_cda != o_cdb);
		if (zero1 && zero2)
			return ovl;
		else
			return le1 && le2;
	endfunction

endpackage

### hdl/tbec_orient_unit.sv
// cross product stage and orientation signs of the four box corners against one triangle edge
module tbec_orient_unit
	import tbec_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  diff_t ex,
	input  diff_t ey,
	input  diff_t cx [NumCorners],
	input  diff_t cy [NumCorners],
	output sgn_t  o  [NumCorners]
);

	prod_t lhs_s2 [NumCorners];
	prod_t rhs_s2 [NumCorners];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NumCorners; k++) begin
				lhs_s2[k] <= ex * cy[k];
				rhs_s2[k] <= ey * cx[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NumCorners; k++)
			o[k] = sgn_cmp(lhs_s2[k], rhs_s2[k]);
	end

endmodule

### hdl/triangle_box_edge_cross_test_core.sv
// Triangle versus axis-aligned box edge contact test. Takes one word per clock
// (three vertices and the left, top, right, bottom bounds) unless a stall on
// out_ready holds the pipeline, and returns one hit word per accepted word.
// hit is 1 when any triangle edge touches or crosses any box edge, exact on
// integer cross products; a shape wholly inside the other without edge contact
// is no hit. The pipeline is input differences, 17x17 cross products (the
// deepest stage), then sign compare and combine. A stall on out_ready backs up
// through the stages without losing or repeating a word.
`include "triangle_box_edge_cross_test_core_assert.svh"

module triangle_box_edge_cross_test_core
	import tbec_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t vert_a_x,
	input  coord_t vert_a_y,
	input  coord_t vert_b_x,
	input  coord_t vert_b_y,
	input  coord_t vert_c_x,
	input  coord_t vert_c_y,
	input  coord_t box_left,
	input  coord_t box_top,
	input  coord_t box_right,
	input  coord_t box_bottom,
	output logic   out_valid,
	input  logic   out_ready,
	output logic   hit
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	pt_t in_tri [NumVerts];
	pt_t in_crn [NumCorners];

	pt_t   tri_s1 [NumVerts];
	pt_t   crn_s1 [NumCorners];
	diff_t ex_s1  [NumVerts];
	diff_t ey_s1  [NumVerts];
	diff_t cx_s1  [NumVerts][NumCorners];
	diff_t cy_s1  [NumVerts][NumCorners];
	sgn_t  sxl_s1 [NumVerts];
	sgn_t  sxr_s1 [NumVerts];
	sgn_t  syt_s1 [NumVerts];
	sgn_t  syb_s1 [NumVerts];
	sgn_t  sbt_s1;
	sgn_t  srl_s1;

	sgn_t                ob_s2  [NumCorners][NumVerts];
	logic [NumPairs-1:0] ovl_s2;
	sgn_t                o_tri  [NumVerts][NumCorners];

	logic [NumPairs-1:0] touch;
	logic                hit_s3;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s3;
	assign hit      = hit_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= in_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	assign in_tri[0] = '{vert_a_x, vert_a_y};
	assign in_tri[1] = '{vert_b_x, vert_b_y};
	assign in_tri[2] = '{vert_c_x, vert_c_y};
	// box outline: left-top, left-bottom, right-bottom, right-top
	assign in_crn[0] = '{box_left, box_top};
	assign in_crn[1] = '{box_left, box_bottom};
	assign in_crn[2] = '{box_right, box_bottom};
	assign in_crn[3] = '{box_right, box_top};

	always_ff @(posedge clk) begin
		if (en1) begin
			sbt_s1 <= sgn_of(d_sub(box_bottom, box_top));
			srl_s1 <= sgn_of(d_sub(box_right, box_left));
			for (int k = 0; k < NumCorners; k++)
				crn_s1[k] <= in_crn[k];
		end
	end

	for (genvar i = 0; i < NumVerts; i++) begin : g_vert
		localparam int I1 = (i + 1) % NumVerts;

		always_ff @(posedge clk) begin
			if (en1) begin
				tri_s1[i] <= in_tri[i];
				ex_s1[i]  <= d_sub(in_tri[I1].x, in_tri[i].x);
				ey_s1[i]  <= d_sub(in_tri[I1].y, in_tri[i].y);
				sxl_s1[i] <= sgn_of(d_sub(in_tri[i].x, box_left));
				sxr_s1[i] <= sgn_of(d_sub(in_tri[i].x, box_right));
				syt_s1[i] <= sgn_of(d_sub(in_tri[i].y, box_top));
				syb_s1[i] <= sgn_of(d_sub(in_tri[i].y, box_bottom));
				for (int k = 0; k < NumCorners; k++) begin
					cx_s1[i][k] <= d_sub(in_crn[k].x, in_tri[i].x);
					cy_s1[i][k] <= d_sub(in_crn[k].y, in_tri[i].y);
				end
			end
		end

		tbec_orient_unit u_orient (
			.clk (clk),
			.en  (en2),
			.ex  (ex_s1[i]),
			.ey  (ey_s1[i]),
			.cx  (cx_s1[i]),
			.cy  (cy_s1[i]),
			.o   (o_tri[i])
		);

		// box edges are axis aligned, so their orientation is a product of two signs
		always_ff @(posedge clk) begin
			if (en2) begin
				ob_s2[0][i] <= sgn_mul(sgn_neg(sbt_s1), sxl_s1[i]);
				ob_s2[1][i] <= sgn_mul(srl_s1, syb_s1[i]);
				ob_s2[2][i] <= sgn_mul(sbt_s1, sxr_s1[i]);
				ob_s2[3][i] <= sgn_mul(sgn_neg(srl_s1), syt_s1[i]);
			end
		end

		for (genvar j = 0; j < NumCorners; j++) begin : g_pair
			localparam int J1 = (j + 1) % NumCorners;
			localparam int P  = i * NumCorners + j;

			key_t ka, kb, kc, kd, min_ab, max_ab, min_cd, max_cd;

			// collinear overlap in lexicographic order
			always_comb begin
				ka     = lex_key(tri_s1[i]);
				kb     = lex_key(tri_s1[I1]);
				kc     = lex_key(crn_s1[j]);
				kd     = lex_key(crn_s1[J1]);
				min_ab = (kb < ka) ? kb : ka;
				max_ab = (kb < ka) ? ka : kb;
				min_cd = (kd < kc) ? kd : kc;
				max_cd = (kd < kc) ? kc : kd;
			end

			always_ff @(posedge clk) begin
				if (en2)
					ovl_s2[P] <= (min_cd <= max_ab) && (min_ab <= max_cd);
			end

			assign touch[P] = seg_touch(o_tri[i][j], o_tri[i][J1],
				ob_s2[j][i], ob_s2[j][I1], ovl_s2[P]);
		end
	end

	always_ff @(posedge clk) begin
		if (en3)
			hit_s3 <= |touch;
	end

	`TBEC_ASSERT_NEXT(a_fill_s1, in_valid && in_ready, v_s1, "accepted word missing in stage 1")
	`TBEC_ASSERT_NEXT(a_move_s2, v_s1 && en2, v_s2, "stage 1 word not moved to stage 2")
	`TBEC_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "empty output stage but input stalled")
	`TBEC_ASSERT_NEXT(a_hold_s2, v_s2 && !en3, v_s2 && $stable(ovl_s2), "stalled stage 2 changed")

endmodule

### sim/tb_triangle_box_edge_cross_test_core.sv
// self-checking testbench for the triangle box edge cross test core
`timescale 1ns / 1ps

module tb_triangle_box_edge_cross_test_core
	import tbec_pkg::*;
();

	localparam int RandomWords = 1800;
	localparam int IdleLimit   = 5000;
	localparam int DrainCycles = 20;
	localparam int LongHold    = 400;
	localparam int HoldEvery   = 300;

	typedef struct {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
		coord_t cx;
		coord_t cy;
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} shape_t;

	typedef struct {
		longint x;
		longint y;
	} spot_t;

	typedef enum logic [1:0] {
		ReadyAlways,
		ReadyCoin,
		ReadySparse,
		ReadyCadence
	} sink_mode_t;

	typedef enum logic [2:0] {
		StyleWide,
		StyleCluster,
		StyleSnapped,
		StyleExtreme,
		StyleDegenerate
	} shape_style_t;

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   in_valid   = 1'b0;
	logic   in_ready;
	coord_t vert_a_x   = '0;
	coord_t vert_a_y   = '0;
	coord_t vert_b_x   = '0;
	coord_t vert_b_y   = '0;
	coord_t vert_c_x   = '0;
	coord_t vert_c_y   = '0;
	coord_t box_left   = '0;
	coord_t box_top    = '0;
	coord_t box_right  = '0;
	coord_t box_bottom = '0;
	logic   out_valid;
	logic   out_ready  = 1'b0;
	logic   hit;

	shape_t     shape_queue[$];
	bit         pending_hits[$];
	shape_t     cur_shape;
	int         burst_left;
	int         gap_left;
	int         hold_left;
	int         long_holds;
	int         mode_left;
	int         sink_phase;
	sink_mode_t sink_mode;
	int         words_sent;
	int         results_seen;
	int         hits_seen;
	int         fault_count;
	int         directed_count;
	int         idle_cycles;

	triangle_box_edge_cross_test_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.vert_a_x   (vert_a_x),
		.vert_a_y   (vert_a_y),
		.vert_b_x   (vert_b_x),
		.vert_b_y   (vert_b_y),
		.vert_c_x   (vert_c_x),
		.vert_c_y   (vert_c_y),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_right  (box_right),
		.box_bottom (box_bottom),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit)
	);

	always #2 clk = ~clk;

	function automatic int turn_sign(input spot_t p, input spot_t q, input spot_t r);
		longint lhs;
		longint rhs;
		lhs = (q.x - p.x) * (r.y - p.y);
		rhs = (q.y - p.y) * (r.x - p.x);
		if (lhs > rhs)
			return 1;
		if (lhs < rhs)
			return -1;
		return 0;
	endfunction

	function automatic bit lex_before(input spot_t p, input spot_t q);
		return (p.x < q.x) || (p.x == q.x && p.y < q.y);
	endfunction

	function automatic bit segments_meet(input spot_t a, input spot_t b,
		input spot_t c, input spot_t d);
		int    s1;
		int    s2;
		spot_t t;
		s1 = turn_sign(a, b, c) * turn_sign(a, b, d);
		s2 = turn_sign(c, d, a) * turn_sign(c, d, b);
		if (s1 == 0 && s2 == 0) begin
			if (lex_before(b, a)) begin
				t = a;
				a = b;
				b = t;
			end
			if (lex_before(d, c)) begin
				t = c;
				c = d;
				d = t;
			end
			return !lex_before(b, c) && !lex_before(d, a);
		end
		return s1 <= 0 && s2 <= 0;
	endfunction

	function automatic bit box_contact_hit(input shape_t s);
		spot_t verts[3];
		spot_t corner[4];
		bit    found;
		verts[0] = '{longint'(s.ax), longint'(s.ay)};
		verts[1] = '{longint'(s.bx), longint'(s.by)};
		verts[2] = '{longint'(s.cx), longint'(s.cy)};
		corner[0] = '{longint'(s.left), longint'(s.top)};
		corner[1] = '{longint'(s.left), longint'(s.bottom)};
		corner[2] = '{longint'(s.right), longint'(s.bottom)};
		corner[3] = '{longint'(s.right), longint'(s.top)};
		found = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 4; j++)
				if (segments_meet(verts[i], verts[(i + 1) % 3], corner[j],
					corner[(j + 1) % 4]))
					found = 1'b1;
		return found;
	endfunction

	function automatic coord_t near(input coord_t base, input int spread);
		return coord_t'(int'(base) + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	function automatic coord_t edge_value();
		case ($urandom_range(0, 6))
			0: return coord_t'(-32768);
			1: return coord_t'(-32767);
			2: return coord_t'(-1);
			3: return coord_t'(0);
			4: return coord_t'(1);
			5: return coord_t'(32766);
			default: return coord_t'(32767);
		endcase
	endfunction

	function automatic coord_t snap(input coord_t lo, input coord_t hi, input coord_t base);
		case ($urandom_range(0, 2))
			0: return lo;
			1: return hi;
			default: return near(base, 30);
		endcase
	endfunction

	function automatic shape_t random_shape();
		shape_t       s;
		shape_style_t style;
		int           r;
		coord_t       bx0;
		coord_t       by0;
		coord_t       t;
		r = $urandom_range(0, 9);
		style = (r < 4) ? StyleWide : (r < 6) ? StyleCluster : (r < 8) ? StyleSnapped :
			(r == 8) ? StyleExtreme : StyleDegenerate;
		bx0 = coord_t'($urandom_range(0, 60000) - 30000);
		by0 = coord_t'($urandom_range(0, 60000) - 30000);
		case (style)
			StyleWide: begin
				s = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom)};
			end
			StyleExtreme: begin
				s = '{edge_value(), edge_value(), edge_value(), edge_value(), edge_value(),
					edge_value(), edge_value(), edge_value(), edge_value(), edge_value()};
			end
			StyleSnapped: begin
				s.left   = near(bx0, 20);
				s.right  = near(bx0, 20);
				s.top    = near(by0, 20);
				s.bottom = near(by0, 20);
				s.ax = snap(s.left, s.right, bx0);
				s.bx = snap(s.left, s.right, bx0);
				s.cx = snap(s.left, s.right, bx0);
				s.ay = snap(s.top, s.bottom, by0);
				s.by = snap(s.top, s.bottom, by0);
				s.cy = snap(s.top, s.bottom, by0);
			end
			default: begin
				s = '{near(bx0, 12), near(by0, 12), near(bx0, 12), near(by0, 12),
					near(bx0, 12), near(by0, 12), near(bx0, 12), near(by0, 12),
					near(bx0, 12), near(by0, 12)};
				if (style == StyleDegenerate) begin
					case ($urandom_range(0, 3))
						0: begin
							s.bx = s.ax;
							s.by = s.ay;
						end
						1: begin
							s.bx = s.ax;
							s.by = s.ay;
							s.cx = s.ax;
							s.cy = s.ay;
						end
						2: begin
							s.right = s.left;
						end
						default: begin
							t = s.left;
							s.left = s.right;
							s.right = t;
							s.top = s.bottom;
						end
					endcase
				end
			end
		endcase
		return s;
	endfunction

	task automatic add_shape(input int ax, input int ay, input int bx, input int by,
		input int cx, input int cy, input int l, input int t, input int r, input int b);
		shape_t s;
		s = '{coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by), coord_t'(cx),
			coord_t'(cy), coord_t'(l), coord_t'(t), coord_t'(r), coord_t'(b)};
		shape_queue.push_back(s);
	endtask

	task automatic report_fault(input string what, input bit want, input bit got);
		fault_count++;
		if (fault_count <= 10)
			$display("%t: %s at result %0d: expected hit=%0b, got hit=%0b",
				$realtime, what, results_seen, want, got);
	endtask

	// sender: bursts of words with random gaps, valid held until accepted
	always @(posedge clk) begin : drive_words
		logic slot_free;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			slot_free = !in_valid || in_ready;
			if (in_valid && in_ready) begin
				pending_hits.push_back(box_contact_hit(cur_shape));
				words_sent++;
			end
			if (slot_free) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (shape_queue.size() > 0) begin
					cur_shape = shape_queue.pop_front();
					burst_left--;
					vert_a_x   <= cur_shape.ax;
					vert_a_y   <= cur_shape.ay;
					vert_b_x   <= cur_shape.bx;
					vert_b_y   <= cur_shape.by;
					vert_c_x   <= cur_shape.cx;
					vert_c_y   <= cur_shape.cy;
					box_left   <= cur_shape.left;
					box_top    <= cur_shape.top;
					box_right  <= cur_shape.right;
					box_bottom <= cur_shape.bottom;
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall patterns that change over time, plus long holds
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (long_holds < 2 && results_seen >= HoldEvery * (1 + 3 * long_holds)) begin
			long_holds++;
			hold_left = LongHold;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 200);
			end
			mode_left--;
			sink_phase++;
			case (sink_mode)
				ReadyAlways:  out_ready <= 1'b1;
				ReadyCoin:    out_ready <= ($urandom_range(0, 1) == 1);
				ReadySparse:  out_ready <= ($urandom_range(0, 3) == 0);
				default:      out_ready <= (sink_phase % 3 != 0);
			endcase
		end
	end

	always @(posedge clk) begin : check_words
		bit want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_hits.size() == 0) begin
				report_fault("unexpected word", 1'b0, hit);
			end else begin
				want = pending_hits.pop_front();
				if (hit !== want)
					report_fault("hit mismatch", want, hit);
				else if (want)
					hits_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("%t: no handshake for %0d cycles, %0d words still expected",
					$realtime, IdleLimit, pending_hits.size());
				$display("tb_triangle_box_edge_cross_test_core: errors");
				$finish;
			end
		end
	end

	initial begin
		add_shape(0, -10, -20, 20, 20, 20, -5, -5, 5, 5);
		add_shape(0, -2, -2, 2, 2, 2, -10, -10, 10, 10);
		add_shape(0, -100, -100, 100, 100, 100, -2, 0, 2, 4);
		add_shape(10, 10, 20, 30, 30, 10, 0, 0, 10, 10);
		add_shape(2, 0, 8, 0, 5, -5, 0, 0, 10, 10);
		add_shape(12, 0, 18, 0, 15, -5, 0, 0, 10, 10);
		add_shape(10, 0, 18, 0, 15, -5, 0, 0, 10, 10);
		add_shape(5, 0, 5, 0, 5, 0, 0, 0, 10, 10);
		add_shape(5, 5, 5, 5, 5, 5, 0, 0, 10, 10);
		add_shape(0, -10, -20, 20, 20, 20, 5, 5, -5, -5);
		add_shape(0, 0, 10, 0, 0, 10, 5, 0, 5, 0);
		add_shape(0, 0, 10, 0, 0, 10, 2, 2, 2, 2);
		add_shape(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768);
		add_shape(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		add_shape(-32768, -32768, 32767, -32768, -32768, 32767,
			-32768, -32768, 32767, 32767);
		add_shape(-32768, 32767, 32767, -32768, 32767, 32767, -100, -100, 100, 100);
		add_shape(-32768, -32768, -32760, -32768, -32768, -32760, 32700, 32700, 32767, 32767);
		add_shape(11, 0, 21, -10, 21, 10, 0, 0, 10, 10);
		add_shape(-5, 5, -5, 5, 15, 5, 0, 0, 10, 10);
		add_shape(0, 0, 10, 0, 5, 20, 5, -10, 5, 10);
		add_shape(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
		add_shape(0, 2, 0, 8, -5, 5, 0, 0, 10, 10);
		add_shape(0, 12, 0, -3, -5, 5, 0, 0, 10, 10);
		directed_count = shape_queue.size();
		repeat (RandomWords)
			shape_queue.push_back(random_shape());

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (words_sent != directed_count + RandomWords || results_seen < words_sent)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("checked %0d shape words (%0d directed), %0d with edge contact",
			results_seen, directed_count, hits_seen);
		$display("long output holds: %0d, mismatches: %0d", long_holds, fault_count);
		if (fault_count == 0 && words_sent == results_seen)
			$display("tb_triangle_box_edge_cross_test_core: clean");
		else
			$display("tb_triangle_box_edge_cross_test_core: errors");
		$finish;
	end

endmodule
